[design/ckx_pkg.sv]
// Shared types, constants and round helpers for the ChaCha20 keystream XOR block.
package ckx_pkg;

	localparam int DATA_W      = 64;
	localparam int VB_W        = 4;
	localparam int WORD_W      = 32;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_W       = 64;
	localparam int STATE_WORDS = 16;
	localparam int KS_WORDS    = 8;
	localparam int POS_W       = 3;
	localparam int BYTES       = DATA_W / 8;

	localparam int ROUND_PAIRS = 10;
	// one step is half a quarter round on all four lanes
	localparam int ROUND_STEPS   = 4 * ROUND_PAIRS;
	localparam int STEP_W        = $clog2(ROUND_STEPS);

	localparam logic [WORD_W-1:0] SIGMA0 = 32'h61707865;
	localparam logic [WORD_W-1:0] SIGMA1 = 32'h3320646e;
	localparam logic [WORD_W-1:0] SIGMA2 = 32'h79622d32;
	localparam logic [WORD_W-1:0] SIGMA3 = 32'h6b206574;

	localparam logic [WORD_W-1:0] COUNTER_START = 32'd1;

	typedef logic [WORD_W-1:0] word_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_KEY_0 = 3'd0,
		CFG_KEY_1 = 3'd1,
		CFG_KEY_2 = 3'd2,
		CFG_KEY_3 = 3'd3,
		CFG_SALT  = 3'd4,
		CFG_IV    = 3'd5
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_ROUND,
		ST_ADD,
		ST_XOR
	} ckx_state_t;

	typedef struct packed {
		logic capture;
		logic load;
		logic round;
		logic half;
		logic diag;
		logic add;
		logic emit;
	} ckx_cmd_t;

	typedef struct packed {
		logic wrap;
	} ckx_sts_t;

	typedef struct packed {
		word_t a;
		word_t b;
		word_t c;
		word_t d;
	} qr_t;

	// First or second half of a quarter round: two add-xor-rotate pairs.
	function automatic qr_t qr_half(input qr_t q, input logic second);
		qr_t   r;
		word_t t;
		r   = q;
		r.a = q.a + q.b;
		t   = q.d ^ r.a;
		r.d = second ? {t[23:0], t[31:24]} : {t[15:0], t[31:16]};
		r.c = q.c + r.d;
		t   = q.b ^ r.c;
		r.b = second ? {t[24:0], t[31:25]} : {t[19:0], t[31:20]};
		return r;
	endfunction

	// Keep byte i when the count exceeds i; counts above eight keep all bytes.
	function automatic logic [DATA_W-1:0] byte_mask(input logic [VB_W-1:0] vb);
		logic [DATA_W-1:0] m;
		m = '0;
		for (int i = 0; i < BYTES; i++) begin
			m[8*i +: 8] = {8{vb > VB_W'(i)}};
		end
		return m;
	endfunction

endpackage

[design/ckx_ifs.sv]
// Valid/ready channel interfaces for message items and result items.
interface ckx_in_if;
	logic                        valid;
	logic                        ready;
	logic [ckx_pkg::DATA_W-1:0]  data_in;
	logic [ckx_pkg::VB_W-1:0]    valid_bytes;
	logic                        first;
	logic                        last;

	modport source(output valid, data_in, valid_bytes, first, last, input ready);
	modport sink(input valid, data_in, valid_bytes, first, last, output ready);
endinterface

interface ckx_out_if;
	logic                        valid;
	logic                        ready;
	logic [ckx_pkg::DATA_W-1:0]  data_out;
	logic [ckx_pkg::VB_W-1:0]    valid_bytes_out;
	logic                        last_out;

	modport source(output valid, data_out, valid_bytes_out, last_out, input ready);
	modport sink(input valid, data_out, valid_bytes_out, last_out, output ready);
endinterface

[design/ckx_ctrl.sv]
// Sequencer: item handshake, block generation steps and result register valid.
module ckx_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              in_first,
	output logic              out_valid,
	input  logic              out_ready,
	output ckx_pkg::ckx_cmd_t cmd,
	input  ckx_pkg::ckx_sts_t sts
);
	import ckx_pkg::*;

	ckx_state_t        state_q, state_d;
	logic [STEP_W-1:0] step_q;
	logic              block_ready_q;
	logic              out_valid_q;
	logic              last_step;
	logic              accept;

	assign last_step = (step_q == STEP_W'(ROUND_STEPS - 1));
	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		cmd.half = step_q[0];
		cmd.diag = step_q[1];
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.capture = 1'b1;
					state_d     = (in_first || !block_ready_q) ? ST_LOAD : ST_XOR;
				end
			end
			ST_LOAD: begin
				cmd.load = 1'b1;
				state_d  = ST_ROUND;
			end
			ST_ROUND: begin
				cmd.round = 1'b1;
				if (last_step) begin
					state_d = ST_ADD;
				end
			end
			ST_ADD: begin
				cmd.add = 1'b1;
				state_d = ST_XOR;
			end
			ST_XOR: begin
				if (!out_valid_q || out_ready) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (cmd.load) begin
			step_q <= '0;
		end else if (cmd.round) begin
			step_q <= step_q + STEP_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_ready_q <= 1'b0;
		end else if (cmd.add) begin
			block_ready_q <= 1'b1;
		end else if (cmd.emit && sts.wrap) begin
			block_ready_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	a_first_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_first) |=> (state_q == ST_LOAD))
		else $error("first item did not start a new block");

	a_round_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND && !last_step) |=> (state_q == ST_ROUND))
		else $error("round sequence left early");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || out_ready))
		else $error("result register overwritten while held");

	a_add_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ADD) |=> block_ready_q)
		else $error("block not marked ready after feed-forward");

endmodule

[design/ckx_dp.sv]
// Datapath: config registers, round state, keystream block and result register.
module ckx_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [ckx_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ckx_pkg::CFG_W-1:0]        cfg_wdata,
	input  logic [ckx_pkg::DATA_W-1:0]       data_in,
	input  logic [ckx_pkg::VB_W-1:0]         valid_bytes,
	input  logic                             first,
	input  logic                             last,
	input  ckx_pkg::ckx_cmd_t                cmd,
	output ckx_pkg::ckx_sts_t                sts,
	output logic [ckx_pkg::DATA_W-1:0]       data_out,
	output logic [ckx_pkg::VB_W-1:0]         valid_bytes_out,
	output logic                             last_out
);
	import ckx_pkg::*;

	logic [63:0]        key0_q, key1_q, key2_q, key3_q, iv_q;
	word_t              salt_q;
	word_t              ctr_q;
	logic [POS_W-1:0]   pos_q;

	logic [DATA_W-1:0]  item_data_q;
	logic [VB_W-1:0]    item_vb_q;
	logic               item_last_q;

	word_t              w_q   [STATE_WORDS];
	word_t              w_rnd [STATE_WORDS];
	word_t              init  [STATE_WORDS];
	logic [DATA_W-1:0]  ks_q  [KS_WORDS];

	logic [1:0]         b_lane [4];
	logic [1:0]         c_lane [4];
	logic [1:0]         d_lane [4];
	qr_t                q_in   [4];
	qr_t                q_out  [4];

	logic [DATA_W-1:0]  data_out_q;
	logic [VB_W-1:0]    vb_out_q;
	logic               last_out_q;

	assign sts.wrap = (pos_q == POS_W'(KS_WORDS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key0_q <= '0;
			key1_q <= '0;
			key2_q <= '0;
			key3_q <= '0;
			salt_q <= '0;
			iv_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_KEY_0: key0_q <= cfg_wdata;
				CFG_KEY_1: key1_q <= cfg_wdata;
				CFG_KEY_2: key2_q <= cfg_wdata;
				CFG_KEY_3: key3_q <= cfg_wdata;
				CFG_SALT:  salt_q <= cfg_wdata[WORD_W-1:0];
				CFG_IV:    iv_q   <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		init[0]  = SIGMA0;
		init[1]  = SIGMA1;
		init[2]  = SIGMA2;
		init[3]  = SIGMA3;
		init[4]  = key0_q[31:0];
		init[5]  = key0_q[63:32];
		init[6]  = key1_q[31:0];
		init[7]  = key1_q[63:32];
		init[8]  = key2_q[31:0];
		init[9]  = key2_q[63:32];
		init[10] = key3_q[31:0];
		init[11] = key3_q[63:32];
		init[12] = ctr_q;
		init[13] = salt_q;
		init[14] = iv_q[31:0];
		init[15] = iv_q[63:32];
	end

	// Four quarter-round lanes; diagonal rounds rotate rows b, c, d by one, two, three.
	always_comb begin
		for (int j = 0; j < STATE_WORDS; j++) begin
			w_rnd[j] = w_q[j];
		end
		for (int i = 0; i < 4; i++) begin
			b_lane[i] = 2'(i) + {1'b0, cmd.diag};
			c_lane[i] = 2'(i) + {cmd.diag, 1'b0};
			d_lane[i] = 2'(i) + {cmd.diag, cmd.diag};
			q_in[i]   = {w_q[{2'b00, 2'(i)}], w_q[{2'b01, b_lane[i]}],
			             w_q[{2'b10, c_lane[i]}], w_q[{2'b11, d_lane[i]}]};
			q_out[i]  = qr_half(q_in[i], cmd.half);
			w_rnd[{2'b00, 2'(i)}]    = q_out[i].a;
			w_rnd[{2'b01, b_lane[i]}] = q_out[i].b;
			w_rnd[{2'b10, c_lane[i]}] = q_out[i].c;
			w_rnd[{2'b11, d_lane[i]}] = q_out[i].d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			w_q <= init;
		end else if (cmd.round) begin
			w_q <= w_rnd;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.add) begin
			for (int k = 0; k < KS_WORDS; k++) begin
				ks_q[k] <= {w_q[2*k+1] + init[2*k+1], w_q[2*k] + init[2*k]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_q <= COUNTER_START;
		end else if (cmd.capture && first) begin
			ctr_q <= COUNTER_START;
		end else if (cmd.add) begin
			ctr_q <= ctr_q + 32'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (cmd.add) begin
			pos_q <= '0;
		end else if (cmd.emit) begin
			pos_q <= pos_q + POS_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_data_q <= data_in;
			item_vb_q   <= valid_bytes;
			item_last_q <= last;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			data_out_q <= (item_data_q ^ ks_q[pos_q]) & byte_mask(item_vb_q);
			vb_out_q   <= item_vb_q;
			last_out_q <= item_last_q;
		end
	end

	assign data_out        = data_out_q;
	assign valid_bytes_out = vb_out_q;
	assign last_out        = last_out_q;

endmodule

[design/chacha20_keystream_xor.sv]
// Top level of the ChaCha20 keystream XOR block: sequencer plus datapath.
//
//  channel    dir  handshake      payload
//  data_ch    in   valid/ready    data_in[63:0], valid_bytes[3:0], first, last
//  result_ch  out  valid/ready    data_out[63:0], valid_bytes_out[3:0], last_out
//  cfg        in   cfg_we only    cfg_index[2:0], cfg_wdata[63:0]
//
// An item that reuses the held keystream block goes through accept and XOR.
// An item that needs a new block (first item, or block used up) goes through
// accept, state load, 40 steps of the shared half-quarter-round unit, feed-forward
// add, XOR. The XOR step waits while the previous result is held and not yet taken.
// Reset clears the sequencer, counter (to 1) and word position; config resets to 0.
// A stalled result holds in the output register while the next item is accepted.
module chacha20_keystream_xor (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [ckx_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ckx_pkg::CFG_W-1:0]     cfg_wdata,
	ckx_in_if.sink                        data_ch,
	ckx_out_if.source                     result_ch
);
	import ckx_pkg::*;

	ckx_cmd_t cmd;
	ckx_sts_t sts;

	// Sequencer: owns the handshakes, the round step count and block-ready flag.
	ckx_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (data_ch.valid),
		.in_ready  (data_ch.ready),
		.in_first  (data_ch.first),
		.out_valid (result_ch.valid),
		.out_ready (result_ch.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// Datapath: config, working state, keystream block, counter and result register.
	ckx_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.data_in         (data_ch.data_in),
		.valid_bytes     (data_ch.valid_bytes),
		.first           (data_ch.first),
		.last            (data_ch.last),
		.cmd             (cmd),
		.sts             (sts),
		.data_out        (result_ch.data_out),
		.valid_bytes_out (result_ch.valid_bytes_out),
		.last_out        (result_ch.last_out)
	);

endmodule
